// ===== rtl/cwct_pkg.sv =====
package cwct_pkg;

  localparam int unsigned WinW = 32;

  // reset values of the configuration registers and latches
  localparam logic [WinW-1:0] LocalWindowRst = 32'd2097152;
  localparam logic [WinW-1:0] InitPeerRst    = 32'd0;
  localparam logic [WinW-1:0] PeerMaxPktRst  = 32'd32768;

  // request operation codes
  typedef enum logic [2:0] {
    OP_INIT         = 3'd0,
    OP_RECEIVE      = 3'd1,
    OP_LOCAL_CREDIT = 3'd2,
    OP_SEND         = 3'd3,
    OP_PEER_ADJUST  = 3'd4
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOCAL_WINDOW = 2'd0,
    CFG_INIT_PEER    = 2'd1,
    CFG_PEER_MAX_PKT = 2'd2
  } cfg_idx_t;

endpackage

// ===== rtl/channel_window_credit_tracker.sv =====
// channel     | direction | handshake         | payload
// ------------+-----------+-------------------+----------------------------------------
// in_         | request   | in_valid/in_stall | in_op, in_amount
// out_        | result    | out_valid/out_stall | accepted, send_cap, replenish, levels
// cfg_        | write     | cfg_we            | cfg_index, cfg_wdata
//
// a request sits in the input register, then its window update and result
// are formed in one pass and land in the result register; one request per
// cycle sustained while out_stall does not hold the result register.
// synchronous active-low reset restores the configured defaults and both windows.
// out_stall holds the result register and, when the input register is also
// full, raises in_stall in the same cycle.
module channel_window_credit_tracker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_op,
  input  logic [cwct_pkg::WinW-1:0] in_amount,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_accepted,
  output logic [cwct_pkg::WinW-1:0] out_send_cap,
  output logic                  out_replenish_due,
  output logic [cwct_pkg::WinW-1:0] out_replenish_amount,
  output logic [cwct_pkg::WinW-1:0] out_local_level,
  output logic [cwct_pkg::WinW-1:0] out_peer_level,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [cwct_pkg::WinW-1:0] cfg_wdata
);
  import cwct_pkg::*;

  // configuration registers
  logic [WinW-1:0] local_window_r;
  logic [WinW-1:0] init_peer_r;
  logic [WinW-1:0] peer_max_pkt_r;

  // channel state
  logic [WinW-1:0] local_left_r, local_left_nxt;
  logic [WinW-1:0] peer_left_r, peer_left_nxt;
  logic [WinW-1:0] full_size_r, full_size_nxt;
  logic [WinW-1:0] max_pkt_r, max_pkt_nxt;

  // input register
  logic            s1_valid_r;
  logic [2:0]      op_r;
  logic [WinW-1:0] amount_r;

  // result register
  logic            out_valid_r;
  logic            accepted_r;
  logic [WinW-1:0] send_cap_r;
  logic            due_r;
  logic [WinW-1:0] topup_r;
  logic [WinW-1:0] local_out_r;
  logic [WinW-1:0] peer_out_r;

  logic            out_free;
  logic            fire;
  logic            accepted;
  logic [WinW:0]   local_sum;
  logic [WinW:0]   peer_sum;
  logic [WinW-1:0] cap_window;
  logic [WinW-1:0] cap_a;
  logic [WinW-1:0] send_cap;
  logic            due;
  logic [WinW-1:0] topup;

  // pipeline flow control
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_window_r <= LocalWindowRst;
      init_peer_r    <= InitPeerRst;
      peer_max_pkt_r <= PeerMaxPktRst;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOCAL_WINDOW: local_window_r <= cfg_wdata;
        CFG_INIT_PEER:    init_peer_r    <= cfg_wdata;
        CFG_PEER_MAX_PKT: peer_max_pkt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      op_r     <= in_op;
      amount_r <= in_amount;
    end
  end

  // saturating sums for credit and peer adjust
  assign local_sum = {1'b0, local_left_r} + {1'b0, amount_r};
  assign peer_sum  = {1'b0, peer_left_r} + {1'b0, amount_r};

  // window update per operation
  always_comb begin
    local_left_nxt = local_left_r;
    peer_left_nxt  = peer_left_r;
    full_size_nxt  = full_size_r;
    max_pkt_nxt    = max_pkt_r;
    accepted       = 1'b0;
    case (op_t'(op_r))
      OP_INIT: begin
        local_left_nxt = local_window_r;
        full_size_nxt  = local_window_r;
        peer_left_nxt  = init_peer_r;
        max_pkt_nxt    = peer_max_pkt_r;
      end
      OP_RECEIVE: begin
        if (amount_r <= local_left_r) begin
          local_left_nxt = local_left_r - amount_r;
          accepted       = 1'b1;
        end
      end
      OP_LOCAL_CREDIT: begin
        local_left_nxt = local_sum[WinW] ? {WinW{1'b1}} : local_sum[WinW-1:0];
      end
      OP_SEND: begin
        if (amount_r <= peer_left_r && amount_r <= max_pkt_r) begin
          peer_left_nxt = peer_left_r - amount_r;
          accepted      = 1'b1;
        end
      end
      OP_PEER_ADJUST: begin
        peer_left_nxt = peer_sum[WinW] ? {WinW{1'b1}} : peer_sum[WinW-1:0];
      end
      default: ;
    endcase
  end

  // send cap: a send sees the peer window before its own update
  assign cap_window = (op_t'(op_r) == OP_SEND) ? peer_left_r : peer_left_nxt;
  assign cap_a      = (amount_r < cap_window) ? amount_r : cap_window;
  assign send_cap   = (cap_a < max_pkt_nxt) ? cap_a : max_pkt_nxt;

  // replenish below half of the full window
  assign due   = local_left_nxt < (full_size_nxt >> 1);
  assign topup = due ? (full_size_nxt - local_left_nxt) : '0;

  // channel state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_left_r <= LocalWindowRst;
      peer_left_r  <= '0;
      full_size_r  <= LocalWindowRst;
      max_pkt_r    <= PeerMaxPktRst;
    end else if (fire) begin
      local_left_r <= local_left_nxt;
      peer_left_r  <= peer_left_nxt;
      full_size_r  <= full_size_nxt;
      max_pkt_r    <= max_pkt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      accepted_r  <= accepted;
      send_cap_r  <= send_cap;
      due_r       <= due;
      topup_r     <= topup;
      local_out_r <= local_left_nxt;
      peer_out_r  <= peer_left_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = accepted_r;
  assign out_send_cap         = send_cap_r;
  assign out_replenish_due    = due_r;
  assign out_replenish_amount = topup_r;
  assign out_local_level      = local_out_r;
  assign out_peer_level       = peer_out_r;

endmodule
